FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/fcfs_pkg.sv
// ----------------------------------------------------------------------------
// fcfs_pkg
// shared widths, record layout, sequencer states and control bundle
// ----------------------------------------------------------------------------
package fcfs_pkg;

  localparam int TIME_W        = 16;
  localparam int ID_W          = 5;
  localparam int FIN_W         = 21;
  localparam int TAT_W         = 20;
  localparam int MAX_PROCS_DEF = 16;

  // one process record as held in the record memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] arrive;
  } rec_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD_I,
    ST_LD_I,
    ST_CMP,
    ST_WB_I,
    ST_ERD,
    ST_EBASE,
    ST_EFIN,
    ST_EOUT
  } state_t;

  // sequencer to emit unit
  typedef struct packed {
    logic clear_clk;
    logic calc_base;
    logic load_out;
    logic last;
    logic dropped;
  } emit_ctl_t;

endpackage

FILE: sv/fcfs_schedule_metrics.sv
// ----------------------------------------------------------------------------
// fcfs_schedule_metrics: first-come-first-served schedule over a loaded list
// load: one record beat per cycle while in the load state; sort and result pace
// are set by the single read port of the record memory, and each result also
// waits out any output stall; reset clears count, overflow flag, schedule clock
// and control; memory contents are left as is
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcfs_schedule_metrics import fcfs_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // record beats
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TIME_W-1:0] in_arrive_time,
  input  logic [TIME_W-1:0] in_burst_time,
  input  logic              in_final_record,
  // result beats
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   out_proc_id,
  output logic [TIME_W-1:0] out_arrive_out,
  output logic [TIME_W-1:0] out_burst_out,
  output logic [FIN_W-1:0]  out_finish_time,
  output logic [TAT_W-1:0]  out_turnaround_time,
  output logic [TAT_W-1:0]  out_wait_time,
  output logic              out_end_of_list,
  output logic              out_dropped
);

  localparam int AW = $clog2(MAX_PROCS);      // record memory address
  localparam int CW = $clog2(MAX_PROCS + 1);  // count, holds MAX_PROCS itself

  // sequencer state and indexes
  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] i_r, i_nxt;   // sort outer position
  logic [AW-1:0] j_r, j_nxt;   // sort inner position
  logic [AW-1:0] k_r, k_nxt;   // emit position
  rec_t          cur_r, cur_nxt; // live copy of record at position i

  // memory port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  rec_t          ram_wdata;
  logic [AW-1:0] ram_raddr;
  rec_t          ram_rdata;

  emit_ctl_t     ectl;

  logic          in_acc;
  logic          out_acc;
  logic          full;
  logic [CW-1:0] cnt_after;
  logic          multi;
  logic          swap;
  logic          j_last;
  logic          i_last;
  logic          k_last;
  logic [31:0]   id_full;
  rec_t          in_rec;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // store full: further records are dropped and flagged
  assign full      = count_r >= CW'(MAX_PROCS);
  assign cnt_after = full ? count_r : count_r + CW'(1);
  assign multi     = cnt_after > CW'(1);

  // exchange compare: position i holds the larger arrival -> swap with j
  assign swap   = cur_r.arrive > ram_rdata.arrive;
  assign j_last = (CW'(j_r) + CW'(1)) >= count_r;
  assign i_last = (CW'(i_r) + CW'(2)) >= count_r;
  assign k_last = (CW'(k_r) + CW'(1)) == count_r;

  // one-based id in load order, kept to the id field width
  assign id_full = 32'(count_r) + 32'd1;
  assign in_rec  = '{id: id_full[ID_W-1:0], burst: in_burst_time, arrive: in_arrive_time};

  fcfs_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (MAX_PROCS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fcfs_emit u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ectl),
    .rd_rec              (ram_rdata),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_proc_id         (out_proc_id),
    .out_arrive_out      (out_arrive_out),
    .out_burst_out       (out_burst_out),
    .out_finish_time     (out_finish_time),
    .out_turnaround_time (out_turnaround_time),
    .out_wait_time       (out_wait_time),
    .out_end_of_list     (out_end_of_list),
    .out_dropped         (out_dropped)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        // a single record needs no sort
        if (in_acc && in_final_record) begin
          state_nxt = multi ? ST_RD_I : ST_ERD;
        end
      end
      ST_RD_I:  state_nxt = ST_LD_I;
      ST_LD_I:  state_nxt = ST_CMP;
      ST_CMP: begin
        if (j_last) begin
          state_nxt = ST_WB_I;
        end
      end
      ST_WB_I:  state_nxt = i_last ? ST_ERD : ST_RD_I;
      ST_ERD:   state_nxt = ST_EBASE;
      ST_EBASE: state_nxt = ST_EFIN;
      ST_EFIN:  state_nxt = ST_EOUT;
      ST_EOUT: begin
        if (out_acc) begin
          state_nxt = out_end_of_list ? ST_LOAD : ST_ERD;
        end
      end
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // outputs: handshake, memory port, emit control
  always_comb begin
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = i_r;
    ram_wdata      = cur_r;
    ram_raddr      = i_r;
    ectl           = '0;
    ectl.last      = k_last;
    ectl.dropped   = ovf_r;
    case (state_r)
      ST_LOAD: begin
        in_ready       = 1'b1;
        ram_we         = in_acc && !full;
        ram_waddr      = count_r[AW-1:0];
        ram_wdata      = in_rec;
        ectl.clear_clk = in_acc && in_final_record;
      end
      ST_RD_I: begin
        ram_raddr = i_r;
      end
      ST_LD_I: begin
        ram_raddr = i_r + AW'(1);
      end
      ST_CMP: begin
        // write back the displaced record at j, fetch j+1 meanwhile
        ram_we    = swap;
        ram_waddr = j_r;
        ram_wdata = cur_r;
        ram_raddr = j_r + AW'(1);
      end
      ST_WB_I: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = cur_r;
      end
      ST_ERD: begin
        ram_raddr = k_r;
      end
      ST_EBASE: begin
        ectl.calc_base = 1'b1;
      end
      ST_EFIN: begin
        ectl.load_out = 1'b1;
      end
      ST_EOUT: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cur_nxt   = cur_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CW'(1);
          end
          if (in_final_record) begin
            i_nxt = '0;
            k_nxt = '0;
          end
        end
      end
      ST_LD_I: begin
        cur_nxt = ram_rdata;
        j_nxt   = i_r + AW'(1);
      end
      ST_CMP: begin
        if (swap) begin
          cur_nxt = ram_rdata;
        end
        j_nxt = j_r + AW'(1);
      end
      ST_WB_I: begin
        i_nxt = i_r + AW'(1);
      end
      ST_EOUT: begin
        if (out_acc) begin
          if (out_end_of_list) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end else begin
            k_nxt = k_r + AW'(1);
          end
        end
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // record copy is payload
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // loading and emitting never overlap
  `ASSERT_IMPLIES(a_load_emit_excl, clk, rst_n, in_ready, !out_valid, "load while result pending")
  // inner sort index stays inside the loaded list
  `ASSERT_IMPLIES(a_sort_in_range, clk, rst_n, state_r == ST_CMP, CW'(j_r) < count_r,
                  "sort index past list")
  // final result beat returns the block to an empty list
  `ASSERT_NEXT(a_list_cleared, clk, rst_n, out_valid && out_ready && out_end_of_list,
               count_r == '0 && in_ready && !ovf_r, "list not cleared after last beat")
  // a drop flag only comes with a full store
  `ASSERT_IMPLIES(a_drop_full, clk, rst_n, out_valid && out_dropped, full,
                  "drop flagged with room left")

endmodule

FILE: sv/fcfs_ram.sv
// ----------------------------------------------------------------------------
// fcfs_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module fcfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/fcfs_emit.sv
// ----------------------------------------------------------------------------
// fcfs_emit
// schedule clock, per-process metrics and the result beat register
// ----------------------------------------------------------------------------
module fcfs_emit import fcfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  emit_ctl_t         ctl,
  input  rec_t              rd_rec,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [ID_W-1:0]   out_proc_id,
  output logic [TIME_W-1:0] out_arrive_out,
  output logic [TIME_W-1:0] out_burst_out,
  output logic [FIN_W-1:0]  out_finish_time,
  output logic [TAT_W-1:0]  out_turnaround_time,
  output logic [TAT_W-1:0]  out_wait_time,
  output logic              out_end_of_list,
  output logic              out_dropped
);

  rec_t              rec_r;
  logic [FIN_W-1:0]  base_r;
  logic [FIN_W-1:0]  base_nxt;
  logic [FIN_W-1:0]  sclk_r;
  logic [FIN_W-1:0]  fin_nxt;
  logic [TAT_W-1:0]  tat_nxt;
  logic [TAT_W-1:0]  wait_nxt;
  logic              valid_r;

  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] arr_r;
  logic [TIME_W-1:0] bur_r;
  logic [FIN_W-1:0]  fin_r;
  logic [TAT_W-1:0]  tat_r;
  logic [TAT_W-1:0]  wait_r;
  logic              last_r;
  logic              drop_r;

  // idle cpu jumps to the arrival
  assign base_nxt = (sclk_r < FIN_W'(rd_rec.arrive)) ? FIN_W'(rd_rec.arrive) : sclk_r;

  // wait = start - arrival, turnaround = wait + burst
  assign fin_nxt  = base_r + FIN_W'(rec_r.burst);
  assign wait_nxt = base_r[TAT_W-1:0] - TAT_W'(rec_r.arrive);
  assign tat_nxt  = base_r[TAT_W-1:0] + TAT_W'(rec_r.burst) - TAT_W'(rec_r.arrive);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sclk_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (ctl.clear_clk) begin
        sclk_r <= '0;
      end else if (ctl.load_out) begin
        sclk_r <= fin_nxt;
      end
      if (ctl.load_out) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.calc_base) begin
      rec_r  <= rd_rec;
      base_r <= base_nxt;
    end
    if (ctl.load_out) begin
      id_r   <= rec_r.id;
      arr_r  <= rec_r.arrive;
      bur_r  <= rec_r.burst;
      fin_r  <= fin_nxt;
      tat_r  <= tat_nxt;
      wait_r <= wait_nxt;
      last_r <= ctl.last;
      drop_r <= ctl.dropped;
    end
  end

  assign out_valid           = valid_r;
  assign out_proc_id         = id_r;
  assign out_arrive_out      = arr_r;
  assign out_burst_out       = bur_r;
  assign out_finish_time     = fin_r;
  assign out_turnaround_time = tat_r;
  assign out_wait_time       = wait_r;
  assign out_end_of_list     = last_r;
  assign out_dropped         = drop_r;

endmodule

FILE: tb/sv/tb_fcfs_schedule_metrics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fcfs_schedule_metrics
// process lists go in one record beat at a time, and each schedule that comes
// back is checked field by field against an independent sort and run of the
// same list; both channels idle and stall at random
// ----------------------------------------------------------------------------
module tb_fcfs_schedule_metrics;
  import fcfs_pkg::*;

  // no-progress limit; the worst quiet stretch is one long output hold plus
  // a full 16-record sort, well under this
  localparam int WATCHDOG_CYCLES = 4000;
  // the long output hold that backs the block up into its input
  localparam int LONG_HOLD       = 300;
  // random record beats, directed ones not counted
  localparam int RANDOM_RECORDS  = 96;
  // from here on neither side idles
  localparam int CALM_FROM       = 75;

  // how arrivals are drawn within one random list
  typedef enum int {
    SPREAD_FULL,   // anywhere in the 16-bit range
    SPREAD_TIES,   // a handful of values, lots of equal arrivals
    SPREAD_GAPS,   // sparse, so the schedule clock idles and jumps
    SPREAD_HIGH    // packed at the top of the range
  } spread_t;

  // one schedule line as it leaves the block
  typedef struct packed {
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] arrive;
    logic [TIME_W-1:0] burst;
    logic [FIN_W-1:0]  finish;
    logic [TAT_W-1:0]  turnaround;
    logic [TAT_W-1:0]  wait_ticks;
    logic              last;
    logic              dropped;
  } metrics_t;

  // holds the list being loaded and the schedule lines still owed
  class fcfs_schedule_book;
    logic [TIME_W-1:0] arrive_held[MAX_PROCS_DEF];
    logic [TIME_W-1:0] burst_held[MAX_PROCS_DEF];
    logic [ID_W-1:0]   id_held[MAX_PROCS_DEF];
    int unsigned       held_count;
    bit                overflowed;
    metrics_t          due_metrics[$];
    int unsigned       mismatch_count;

    function new();
      held_count     = 0;
      overflowed     = 1'b0;
      mismatch_count = 0;
    endfunction

    function int unsigned pending();
      return due_metrics.size();
    endfunction

    // one accepted record beat; a final beat sorts and runs the list
    function void note_record(logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bur,
                              logic is_last);
      logic [TIME_W-1:0] t_arr, t_bur;
      logic [ID_W-1:0]   t_id;
      logic [FIN_W-1:0]  sched_clk;
      logic [TAT_W-1:0]  tat;
      metrics_t          m;
      int unsigned       i, j;
      if (held_count < MAX_PROCS_DEF) begin
        arrive_held[held_count] = arr;
        burst_held[held_count]  = bur;
        id_held[held_count]     = ID_W'(held_count + 1);
        held_count++;
      end else begin
        overflowed = 1'b1;
      end
      if (!is_last) return;

      // exchange sort, strict compare, so ties stay where the swaps leave them
      for (i = 0; i + 1 < held_count; i++) begin
        for (j = i + 1; j < held_count; j++) begin
          if (arrive_held[i] > arrive_held[j]) begin
            t_arr = arrive_held[i]; arrive_held[i] = arrive_held[j]; arrive_held[j] = t_arr;
            t_bur = burst_held[i];  burst_held[i]  = burst_held[j];  burst_held[j]  = t_bur;
            t_id  = id_held[i];     id_held[i]     = id_held[j];     id_held[j]     = t_id;
          end
        end
      end

      sched_clk = '0;
      for (i = 0; i < held_count; i++) begin
        // idle cpu jumps to the arrival
        if (sched_clk < FIN_W'(arrive_held[i])) sched_clk = FIN_W'(arrive_held[i]);
        sched_clk = sched_clk + FIN_W'(burst_held[i]);
        tat = TAT_W'(sched_clk - FIN_W'(arrive_held[i]));
        m.proc_id    = id_held[i];
        m.arrive     = arrive_held[i];
        m.burst      = burst_held[i];
        m.finish     = sched_clk;
        m.turnaround = tat;
        m.wait_ticks = tat - TAT_W'(burst_held[i]);
        m.last       = (i + 1 == held_count);
        m.dropped    = overflowed;
        due_metrics.push_back(m);
      end
      held_count = 0;
      overflowed = 1'b0;
    endfunction

    function void compare_field(string field, longint unsigned want,
                                longint unsigned seen);
      if (want != seen) begin
        $display("%0t ns: %s mismatch, expected %0d actual %0d",
                 $time, field, want, seen);
        mismatch_count++;
      end
    endfunction

    function void check_metrics(metrics_t got);
      metrics_t want;
      if (due_metrics.size() == 0) begin
        $display("%0t ns: unexpected result beat, proc_id %0d", $time, got.proc_id);
        mismatch_count++;
        return;
      end
      want = due_metrics.pop_front();
      compare_field("proc_id",         want.proc_id,    got.proc_id);
      compare_field("arrive_out",      want.arrive,     got.arrive);
      compare_field("burst_out",       want.burst,      got.burst);
      compare_field("finish_time",     want.finish,     got.finish);
      compare_field("turnaround_time", want.turnaround, got.turnaround);
      compare_field("wait_time",       want.wait_ticks, got.wait_ticks);
      compare_field("end_of_list",     want.last,       got.last);
      compare_field("dropped",         want.dropped,    got.dropped);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [TIME_W-1:0] in_arrive_time = '0;
  logic [TIME_W-1:0] in_burst_time = '0;
  logic              in_final_record = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ID_W-1:0]   out_proc_id;
  logic [TIME_W-1:0] out_arrive_out;
  logic [TIME_W-1:0] out_burst_out;
  logic [FIN_W-1:0]  out_finish_time;
  logic [TAT_W-1:0]  out_turnaround_time;
  logic [TAT_W-1:0]  out_wait_time;
  logic              out_end_of_list;
  logic              out_dropped;

  fcfs_schedule_book schedule_book;

  // idle odds: 0 means never idle, otherwise about one beat in odds+1
  int unsigned src_gap_odds  = 0;
  int unsigned sink_gap_odds = 0;
  bit          hold_request  = 1'b0;
  int unsigned sink_stall_left = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned sent_count    = 0;
  metrics_t    seen_beat;

  fcfs_schedule_metrics DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_arrive_time      (in_arrive_time),
    .in_burst_time       (in_burst_time),
    .in_final_record     (in_final_record),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_proc_id         (out_proc_id),
    .out_arrive_out      (out_arrive_out),
    .out_burst_out       (out_burst_out),
    .out_finish_time     (out_finish_time),
    .out_turnaround_time (out_turnaround_time),
    .out_wait_time       (out_wait_time),
    .out_end_of_list     (out_end_of_list),
    .out_dropped         (out_dropped)
  );

  always #1 clk = ~clk;

  // result side: random stall bursts, plus one long hold when asked for
  always @(posedge clk) begin
    if (sink_stall_left != 0) begin
      sink_stall_left--;
      out_ready <= 1'b0;
    end else if (hold_request) begin
      hold_request    = 1'b0;
      sink_stall_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (sink_gap_odds != 0 && $urandom_range(0, sink_gap_odds) == 0) begin
      // start a burst of stalled cycles of random length
      sink_stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // beat monitor: values read here are the ones present at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && in_ready) begin
        schedule_book.note_record(in_arrive_time, in_burst_time, in_final_record);
        quiet_cycles = 0;
      end
      if (out_valid && out_ready) begin
        seen_beat.proc_id    = out_proc_id;
        seen_beat.arrive     = out_arrive_out;
        seen_beat.burst      = out_burst_out;
        seen_beat.finish     = out_finish_time;
        seen_beat.turnaround = out_turnaround_time;
        seen_beat.wait_ticks = out_wait_time;
        seen_beat.last       = out_end_of_list;
        seen_beat.dropped    = out_dropped;
        schedule_book.check_metrics(seen_beat);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("[fcfs_schedule_metrics] ERROR");
        $finish;
      end
    end
  end

  // one record beat; called right after a rising edge, returns at the edge
  // where the beat was taken
  task automatic send_record(input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] bur,
                             input logic is_last);
    if (src_gap_odds != 0 && $urandom_range(0, src_gap_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_arrive_time  <= arr;
    in_burst_time   <= bur;
    in_final_record <= is_last;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every owed schedule line is back
  task automatic pause_for_results();
    in_valid <= 1'b0;
    // let the monitor see the last beat before polling
    @(posedge clk);
    while (schedule_book.pending() != 0) @(posedge clk);
  endtask

  // one random list, the final mark on its last record
  task automatic send_random_list(input int unsigned len);
    spread_t           spread;
    int unsigned       burst_mode, k;
    logic [TIME_W-1:0] arr, bur;
    spread     = spread_t'($urandom_range(0, 3));
    burst_mode = $urandom_range(0, 2);
    for (k = 0; k < len; k++) begin
      case (spread)
        SPREAD_FULL: arr = TIME_W'($urandom_range(0, 16'hFFFF));
        SPREAD_TIES: arr = TIME_W'($urandom_range(0, 7));
        SPREAD_GAPS: arr = TIME_W'($urandom_range(0, 3000));
        default:     arr = 16'hFFFF - TIME_W'($urandom_range(0, 15));
      endcase
      case (burst_mode)
        0:       bur = TIME_W'($urandom_range(0, 16'hFFFF));
        1:       bur = TIME_W'($urandom_range(0, 20));
        default: bur = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      endcase
      send_record(arr, bur, k + 1 == len);
      sent_count++;
    end
  endtask

  initial begin
    int unsigned list_no, len;
    schedule_book = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, both sides idling now and then
    src_gap_odds  = 3;
    sink_gap_odds = 3;
    // single record, all zero
    send_record(16'h0000, 16'h0000, 1'b1);
    // single record at the top of both ranges
    send_record(16'hFFFF, 16'hFFFF, 1'b1);
    // out of order with equal arrivals, last one after an idle stretch
    send_record(16'd5,  16'd3, 1'b0);
    send_record(16'd2,  16'd4, 1'b0);
    send_record(16'd5,  16'd1, 1'b0);
    send_record(16'd2,  16'd0, 1'b0);
    send_record(16'd40, 16'd7, 1'b1);
    // full store plus a final record that is dropped; all at max, so finish,
    // turnaround and wait reach their largest values
    for (int k = 0; k < MAX_PROCS_DEF + 1; k++)
      send_record(16'hFFFF, 16'hFFFF, k == MAX_PROCS_DEF);
    pause_for_results();

    // random lists, mostly short, now and then long enough to overflow
    list_no = 0;
    while (sent_count < RANDOM_RECORDS) begin
      list_no++;
      if (sent_count >= CALM_FROM) begin
        src_gap_odds  = 0;
        sink_gap_odds = 0;
      end else begin
        src_gap_odds  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
        sink_gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
      end
      // hold results back while the next lists keep coming
      if (list_no == 3) hold_request = 1'b1;
      if (list_no == 7) pause_for_results();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 8);
      send_random_list(len);
    end

    pause_for_results();
    // then idle on for anything stray
    repeat (20) @(posedge clk);
    if (schedule_book.mismatch_count == 0 && schedule_book.pending() == 0) begin
      $display("[fcfs_schedule_metrics] OK");
    end else begin
      $display("[fcfs_schedule_metrics] ERROR");
    end
    $finish;
  end

endmodule
